### design/infix_int_expression_evaluator_defines.svh
// Assertion macros shared by the checker
`ifndef INFIX_INT_EXPRESSION_EVALUATOR_DEFINES_SVH
`define INFIX_INT_EXPRESSION_EVALUATOR_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define IIE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define IIE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### design/iie_pkg.sv
// Package: shared types and constants of the expression evaluator
`default_nettype none
package iie_pkg;
    // character classes produced by the front end
    typedef enum logic [2:0] {
        CLS_SPACE = 3'd0,
        CLS_DIGIT = 3'd1,
        CLS_PLUS  = 3'd2,
        CLS_MINUS = 3'd3,
        CLS_MUL   = 3'd4,
        CLS_DIV   = 3'd5,
        CLS_BAD   = 3'd6,
        CLS_END   = 3'd7
    } cls_t;

    // queue entry between front and back
    typedef struct packed {
        cls_t       cls;
        logic [3:0] digit;
    } tok_t;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_WRONG    = 3'd1;
    localparam logic [2:0] ST_OVERFLOW = 3'd2;
    localparam logic [2:0] ST_DIVZERO  = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    localparam logic [2:0] PH_EMPTY   = 3'd0;
    localparam logic [2:0] PH_OPERAND = 3'd1;
    localparam logic [2:0] PH_DIGIT   = 3'd2;
    localparam logic [2:0] PH_NUMBER  = 3'd3;
    localparam logic [2:0] PH_AFTER   = 3'd4;

    localparam logic [1:0] MUL_NONE = 2'd0;
    localparam logic [1:0] MUL_MUL  = 2'd1;
    localparam logic [1:0] MUL_DIV  = 2'd2;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
endpackage
`default_nettype wire

### design/iie_front.sv
// Front end: character classification and a two-entry token queue
`default_nettype none
module iie_front
    import iie_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] char_code,
    input  wire logic       end_mark,
    input  wire logic       in_valid,
    output logic            in_ready,
    output tok_t            tok,
    output logic            tok_valid,
    input  wire logic       tok_ready
);
    tok_t       mem_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, rp_reg;
    tok_t       t_in;
    logic       push, pop;

    // classify the incoming byte
    always_comb
    begin
        t_in.digit = 4'(char_code - CH_ZERO);
        if (end_mark)
            t_in.cls = CLS_END;
        else if (char_code == CH_SP || (char_code >= CH_TAB && char_code <= CH_CR))
            t_in.cls = CLS_SPACE;
        else if (char_code >= CH_ZERO && char_code <= CH_NINE)
            t_in.cls = CLS_DIGIT;
        else if (char_code == CH_PLUS)
            t_in.cls = CLS_PLUS;
        else if (char_code == CH_MINUS)
            t_in.cls = CLS_MINUS;
        else if (char_code == CH_STAR)
            t_in.cls = CLS_MUL;
        else if (char_code == CH_SLASH)
            t_in.cls = CLS_DIV;
        else
            t_in.cls = CLS_BAD;
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign tok_valid = (cnt_reg != 2'd0);
    assign tok       = mem_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = tok_valid && tok_ready;
    assign cnt_next  = cnt_reg + 2'(push) - 2'(pop);

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= t_in;
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
        end
    end
endmodule
`default_nettype wire

### design/iie_back.sv
// Back end: parser state, checked arithmetic and serial divider
`default_nettype none
module iie_back
    import iie_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  tok_t                              tok,
    input  wire logic                         tok_valid,
    output logic                              tok_ready,
    output logic signed [VALUE_BITS-1:0]      value,
    output logic [2:0]                        status,
    output logic                              out_valid,
    input  wire logic                         out_ready
);
    localparam int W  = VALUE_BITS;
    localparam int CW = $clog2(W + 1);
    localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_MUL  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic signed [W-1:0] sum_reg, sum_next, term_reg, term_next, num_reg, num_next;
    logic add_reg, add_next, neg_reg, neg_next;
    logic [1:0] mop_reg, mop_next;
    logic [2:0] ph_reg, ph_next, err_reg, err_next;
    logic signed [W-1:0] val_reg, val_next;
    logic [2:0] st_reg, st_next;
    // held token while a multi-cycle close runs
    tok_t hold_reg, hold_next;
    // divider
    logic [W-1:0] q_reg, q_next, r_reg, r_next, d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic qneg_reg, qneg_next;
    // multiplier result
    logic signed [2*W-1:0] prod_reg, prod_next;

    logic [W:0] rtrial;
    logic signed [W+4:0] n10;
    logic tok_take;

    function automatic logic ovf_w(input logic signed [W:0] x);
        ovf_w = (x[W] != x[W-1]);
    endfunction

    assign tok_take = tok_valid && tok_ready;
    assign tok_ready = (state_reg == S_IDLE) && !out_valid;
    assign out_valid = (state_reg == S_OUT);
    assign value = val_reg;
    assign status = st_reg;
    assign rtrial = {r_reg, q_reg[W-1]} - {1'b0, d_reg};

    // sequential parse control
    always_comb
    begin
        logic signed [W:0] tsum;
        logic signed [W+4:0] nd;
        logic close_num, do_next;
        logic [2:0] eff_ph;
        tok_t t;
        state_next = state_reg;
        sum_next = sum_reg; term_next = term_reg; num_next = num_reg;
        add_next = add_reg; neg_next = neg_reg; mop_next = mop_reg;
        ph_next = ph_reg; err_next = err_reg; val_next = val_reg; st_next = st_reg;
        hold_next = hold_reg; q_next = q_reg; r_next = r_reg; d_next = d_reg;
        cnt_next = cnt_reg; qneg_next = qneg_reg; prod_next = prod_reg;
        n10 = '0;
        tsum = '0; nd = '0; close_num = 1'b0; do_next = 1'b0;
        eff_ph = ph_reg; t = tok;
        case (state_reg)
            S_IDLE:
            begin
                if (tok_take)
                begin
                    hold_next = tok;
                    do_next = 1'b1;
                    if (err_reg == ST_OK && ph_reg == PH_NUMBER &&
                        !(tok.cls == CLS_DIGIT))
                    begin
                        // number ends: apply to term first
                        close_num = 1'b1;
                        do_next = 1'b0;
                    end
                end
            end
            S_MUL:
            begin
                // check registered product, then resume the held token
                if (prod_reg[2*W-1:W-1] != {(W+1){prod_reg[W-1]}})
                begin
                    if (err_next == ST_OK) err_next = ST_OVERFLOW;
                end
                else
                    term_next = prod_reg[W-1:0];
                num_next = '0; neg_next = 1'b0; ph_next = PH_AFTER;
                t = hold_reg; do_next = 1'b1; eff_ph = PH_AFTER;
                state_next = S_IDLE;
            end
            S_DIV:
            begin
                r_next = rtrial[W] ? {r_reg[W-2:0], q_reg[W-1]} : rtrial[W-1:0];
                q_next = {q_reg[W-2:0], ~rtrial[W]};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    term_next = qneg_reg ? -$signed(q_next) : $signed(q_next);
                    num_next = '0; neg_next = 1'b0; ph_next = PH_AFTER;
                    t = hold_reg; do_next = 1'b1; eff_ph = PH_AFTER;
                    state_next = S_IDLE;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase

        if (close_num)
        begin
            if (mop_reg == MUL_MUL)
            begin
                prod_next = term_reg * num_reg;
                state_next = S_MUL;
            end
            else if (mop_reg == MUL_DIV)
            begin
                if (num_reg == '0)
                begin
                    err_next = ST_DIVZERO;
                    ph_next = PH_AFTER;
                    t = tok; do_next = 1'b1; eff_ph = PH_AFTER;
                end
                else if (term_reg == VMIN && num_reg == -1)
                begin
                    err_next = ST_OVERFLOW;
                    ph_next = PH_AFTER;
                    t = tok; do_next = 1'b1; eff_ph = PH_AFTER;
                end
                else
                begin
                    q_next = term_reg[W-1] ? W'(-term_reg) : W'(term_reg);
                    d_next = num_reg[W-1] ? W'(-num_reg) : W'(num_reg);
                    r_next = '0;
                    qneg_next = term_reg[W-1] ^ num_reg[W-1];
                    cnt_next = CW'(W);
                    state_next = S_DIV;
                end
            end
            else
            begin
                term_next = num_reg; num_next = '0; neg_next = 1'b0; ph_next = PH_AFTER;
                t = tok; do_next = 1'b1; eff_ph = PH_AFTER;
            end
        end

        // handle one token once any pending number close is done
        if (do_next)
        begin
            tsum = add_reg ? ($signed({sum_reg[W-1], sum_reg}) - {term_next[W-1], term_next})
                           : ($signed({sum_reg[W-1], sum_reg}) + {term_next[W-1], term_next});
            n10 = $signed({{5{num_reg[W-1]}}, num_reg}) * 10;
            nd = neg_reg ? n10 - (W+5)'(t.digit) : n10 + (W+5)'(t.digit);
            if (t.cls == CLS_END)
            begin
                st_next = err_next;
                if (err_next == ST_OK)
                begin
                    if (eff_ph == PH_EMPTY) st_next = ST_EMPTY;
                    else if (eff_ph != PH_AFTER) st_next = ST_WRONG;
                    else if (ovf_w(tsum)) st_next = ST_OVERFLOW;
                end
                val_next = (st_next == ST_OK) ? tsum[W-1:0] : '0;
                sum_next = '0; term_next = '0; num_next = '0; add_next = 1'b0;
                neg_next = 1'b0; mop_next = MUL_NONE; ph_next = PH_EMPTY;
                err_next = ST_OK;
                state_next = S_OUT;
            end
            else if (err_next == ST_OK)
            begin
                if (eff_ph == PH_EMPTY) eff_ph = PH_OPERAND;
                ph_next = eff_ph;
                if (t.cls == CLS_SPACE)
                    ;
                else if (eff_ph == PH_AFTER)
                begin
                    case (t.cls)
                        CLS_MUL: begin mop_next = MUL_MUL; ph_next = PH_OPERAND; end
                        CLS_DIV: begin mop_next = MUL_DIV; ph_next = PH_OPERAND; end
                        CLS_PLUS, CLS_MINUS:
                        begin
                            if (ovf_w(tsum)) err_next = ST_OVERFLOW;
                            else sum_next = tsum[W-1:0];
                            add_next = (t.cls == CLS_MINUS);
                            mop_next = MUL_NONE; ph_next = PH_OPERAND;
                        end
                        CLS_DIGIT:
                        begin
                            if (ovf_w(tsum)) err_next = ST_OVERFLOW;
                            else begin sum_next = tsum[W-1:0]; err_next = ST_WRONG; end
                        end
                        default: err_next = ST_WRONG;
                    endcase
                end
                else if (t.cls == CLS_DIGIT)
                begin
                    if (nd > $signed({5'b0, VMAX}) || nd < $signed({5'h1F, VMIN}))
                        err_next = ST_OVERFLOW;
                    else
                        num_next = nd[W-1:0];
                    ph_next = PH_NUMBER;
                end
                else if (eff_ph == PH_OPERAND && (t.cls == CLS_PLUS || t.cls == CLS_MINUS))
                begin
                    neg_next = (t.cls == CLS_MINUS);
                    ph_next = PH_DIGIT;
                end
                else
                    err_next = ST_WRONG;
            end
        end
    end

    // state and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sum_reg <= '0; term_reg <= '0; num_reg <= '0;
            add_reg <= 1'b0; neg_reg <= 1'b0; mop_reg <= MUL_NONE;
            ph_reg <= PH_EMPTY; err_reg <= ST_OK; cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sum_reg <= sum_next; term_reg <= term_next; num_reg <= num_next;
            add_reg <= add_next; neg_reg <= neg_next; mop_reg <= mop_next;
            ph_reg <= ph_next; err_reg <= err_next; cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next; st_reg <= st_next; hold_reg <= hold_next;
        q_reg <= q_next; r_reg <= r_next; d_reg <= d_next; qneg_reg <= qneg_next;
        prod_reg <= prod_next;
    end
endmodule
`default_nettype wire

### design/infix_int_expression_evaluator.sv
// Top level: streaming infix integer expression evaluator
// Usage:
//   Input channel (char_code, end_mark, in_valid/in_ready) takes one ASCII
//   character per transfer; a transfer with end_mark set closes the
//   expression. Output channel (value, status, out_valid/out_ready) gives one
//   result per closed expression.
//   Characters enter a two-entry queue, so the front keeps taking transfers
//   while the back works. Most characters the back handles directly; the end
//   of a number applied by '*' goes through a registered product check, and
//   one applied by '/' runs VALUE_BITS steps of the restoring divider; the
//   back takes no new character meanwhile. The result holds until taken;
//   while out_ready is low the back stops and the queue fills, then in_ready
//   drops.
//   Reset clears the queue and returns the parser to the empty state.
`default_nettype none
module infix_int_expression_evaluator
    import iie_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [7:0]              char_code,
    input  wire logic                    end_mark,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    output logic signed [VALUE_BITS-1:0] value,
    output logic [2:0]                   status,
    output logic                         out_valid,
    input  wire logic                    out_ready
);
    tok_t tok;
    logic tok_valid, tok_ready;

    iie_front u_front (
        .clk(clk), .rst_n(rst_n), .char_code(char_code), .end_mark(end_mark),
        .in_valid(in_valid), .in_ready(in_ready), .tok(tok),
        .tok_valid(tok_valid), .tok_ready(tok_ready)
    );

    iie_back #(.VALUE_BITS(VALUE_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .tok(tok), .tok_valid(tok_valid),
        .tok_ready(tok_ready), .value(value), .status(status),
        .out_valid(out_valid), .out_ready(out_ready)
    );
endmodule
`default_nettype wire

### design/iie_checker.sv
// Port checker for the expression evaluator, bound to the top level
`default_nettype none
`include "infix_int_expression_evaluator_defines.svh"
module iie_checker
    import iie_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic [VALUE_BITS-1:0] value,
    input wire logic [2:0]            status,
    input wire logic                  out_valid,
    input wire logic                  out_ready
);
    `IIE_ASSERT_IMP(a_status_range, clk, rst_n, out_valid, status <= ST_EMPTY)
    `IIE_ASSERT_IMP(a_value_zero_on_err, clk, rst_n, out_valid && status != ST_OK, value == '0)
    `IIE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(value) && $stable(status))
    `IIE_ASSERT_NEXT(a_one_result, clk, rst_n, out_valid && out_ready, !out_valid)
endmodule

bind infix_int_expression_evaluator iie_checker #(.VALUE_BITS(VALUE_BITS)) u_iie_checker (
    .clk(clk), .rst_n(rst_n), .value(value),
    .status(status), .out_valid(out_valid), .out_ready(out_ready)
);
`default_nettype wire

### test/tb_infix_int_expression_evaluator.sv
// Testbench for the streaming infix integer expression evaluator
`timescale 1ns / 100ps
module tb_infix_int_expression_evaluator;
    import iie_pkg::*;

    localparam longint VMAX        = 64'sd2147483647;
    localparam longint VMIN        = -VMAX - 1;
    localparam int     CYCLE_LIMIT = 2000000;
    localparam int     DRAIN_WAIT  = 60;
    localparam int     RAND_ITEMS  = 1630;

    typedef struct {
        logic signed [31:0] value;
        logic [2:0]         status;
    } eval_result_t;

    logic                clk;
    logic                rst_n;
    logic [7:0]          char_code;
    logic                end_mark;
    logic                in_valid;
    logic                in_ready;
    logic signed [31:0]  value;
    logic [2:0]          status;
    logic                out_valid;
    logic                out_ready;

    eval_result_t pending_results[$];
    int           mismatch_count;
    int           char_count;
    int           expr_count;
    int           result_count;
    int           cycle_count;

    // evaluator shadow state
    longint     sum_acc;
    longint     term_acc;
    longint     number_acc;
    logic       add_minus;
    logic [1:0] mul_op;
    logic       number_neg;
    logic [2:0] phase;
    logic [2:0] err_code;

    infix_int_expression_evaluator #(.VALUE_BITS(32)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_code (char_code),
        .end_mark  (end_mark),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // shadow evaluator
    // ------------------------------------------------------------------
    function automatic bit fits(longint v);
        return v >= VMIN && v <= VMAX;
    endfunction

    function automatic void eval_clear();
        sum_acc    = 0;
        term_acc   = 0;
        number_acc = 0;
        add_minus  = 1'b0;
        mul_op     = MUL_NONE;
        number_neg = 1'b0;
        phase      = PH_EMPTY;
        err_code   = ST_OK;
    endfunction

    function automatic void flag_error(logic [2:0] e);
        if (err_code == ST_OK)
            err_code = e;
    endfunction

    // apply the finished number to the term
    function automatic void finish_number();
        longint p;
        if (mul_op == MUL_MUL)
        begin
            p = term_acc * number_acc;
            if (fits(p))
                term_acc = p;
            else
                flag_error(ST_OVERFLOW);
        end
        else if (mul_op == MUL_DIV)
        begin
            if (number_acc == 0)
                flag_error(ST_DIVZERO);
            else if (term_acc == VMIN && number_acc == -1)
                flag_error(ST_OVERFLOW);
            else
                term_acc = term_acc / number_acc;
        end
        else
            term_acc = number_acc;
        number_acc = 0;
        number_neg = 1'b0;
        phase      = PH_AFTER;
    endfunction

    // apply the finished term to the sum
    function automatic void finish_term();
        longint r;
        r = add_minus ? sum_acc - term_acc : sum_acc + term_acc;
        if (fits(r))
            sum_acc = r;
        else
            flag_error(ST_OVERFLOW);
    endfunction

    function automatic void push_digit(logic [7:0] c);
        longint p;
        longint r;
        p = number_acc * 10;
        r = number_neg ? p - longint'(c - CH_ZERO) : p + longint'(c - CH_ZERO);
        if (fits(p) && fits(r))
            number_acc = r;
        else
            flag_error(ST_OVERFLOW);
        phase = PH_NUMBER;
    endfunction

    function automatic void eval_char(logic [7:0] c);
        bit digit;
        bit space;
        digit = c >= CH_ZERO && c <= CH_NINE;
        space = c == CH_SP || (c >= CH_TAB && c <= CH_CR);
        if (err_code != ST_OK)
            return;
        if (phase == PH_EMPTY)
            phase = PH_OPERAND;
        if (phase == PH_NUMBER)
        begin
            if (digit)
            begin
                push_digit(c);
                return;
            end
            finish_number();
            if (err_code != ST_OK)
                return;
        end
        if (space)
            return;
        if (phase == PH_OPERAND || phase == PH_DIGIT)
        begin
            if (digit)
                push_digit(c);
            else if (phase == PH_OPERAND && (c == CH_MINUS || c == CH_PLUS))
            begin
                number_neg = (c == CH_MINUS);
                phase      = PH_DIGIT;
            end
            else
                flag_error(ST_WRONG);
            return;
        end
        // operator awaited
        if (c == CH_STAR || c == CH_SLASH)
        begin
            mul_op = (c == CH_STAR) ? MUL_MUL : MUL_DIV;
            phase  = PH_OPERAND;
        end
        else if (c == CH_PLUS || c == CH_MINUS)
        begin
            finish_term();
            add_minus = (c == CH_MINUS);
            mul_op    = MUL_NONE;
            phase     = PH_OPERAND;
        end
        else if (digit)
        begin
            finish_term();
            flag_error(ST_WRONG);
        end
        else
            flag_error(ST_WRONG);
    endfunction

    function automatic eval_result_t eval_close();
        eval_result_t res;
        if (err_code == ST_OK)
        begin
            if (phase == PH_EMPTY)
                flag_error(ST_EMPTY);
            else if (phase == PH_OPERAND || phase == PH_DIGIT)
                flag_error(ST_WRONG);
            else
            begin
                if (phase == PH_NUMBER)
                    finish_number();
                if (err_code == ST_OK)
                    finish_term();
            end
        end
        res.status = err_code;
        res.value  = (err_code == ST_OK) ? sum_acc[31:0] : 32'd0;
        eval_clear();
        return res;
    endfunction

    // ------------------------------------------------------------------
    // input side: one transfer, called at a falling edge
    // ------------------------------------------------------------------
    task automatic send_item(logic [7:0] c, logic e);
        int gap;
        gap = $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        end_mark  <= e;
        if (e)
        begin
            pending_results.push_back(eval_close());
            expr_count++;
        end
        else
        begin
            eval_char(c);
            char_count++;
        end
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic send_expr(string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    // output side: random stall before each transfer
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = $urandom_range(0, 6);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        eval_result_t exp_res;
        if (rst_n && out_valid && out_ready)
        begin
            result_count++;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: value %0d status %0d", value, status);
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (value !== exp_res.value || status !== exp_res.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result %0d: expected value %0d status %0d, got %0d %0d",
                                 result_count, exp_res.value, exp_res.status,
                                 value, status);
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_valid_exprs();
        send_expr("1+2*3");
        send_expr("-2147483648");
        send_expr("2147483647");
        send_expr(" 7 / -2 ");
        send_expr("-7/2*3-10/3");
        send_expr("+5\t*\n-4\r");
        send_expr("100 * 0 - 2147483647 - 1");
    endtask

    task automatic test_error_cases();
        send_expr("");
        send_expr("   ");
        send_expr("2147483647+1");
        send_expr("2147483648");
        send_expr("-2147483648/-1");
        send_expr("5/0");
        send_expr("65536*65536");
        send_expr("1 2");
        send_expr("1+");
        send_expr("--1");
        send_expr("3a");
        send_expr("9/0x");
        send_expr("4 *");
        // bad bytes at the extremes of the code range
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'h31, 1'b1);
    endtask

    function automatic string rand_number();
        string s;
        longint mag;
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            mag = $urandom_range(0, 99);
        else if (pick < 16)
            mag = $urandom_range(0, 99999);
        else if (pick < 18)
            mag = $urandom;
        else
            mag = 64'd2147483647 + $urandom_range(0, 1);
        s = $sformatf("%0d", mag);
        case ($urandom_range(0, 3))
            0: s = {"-", s};
            1: s = {"+", s};
            default: ;
        endcase
        return s;
    endfunction

    function automatic string rand_space();
        string ws;
        ws = " \t\n\v\f\r";
        if ($urandom_range(0, 3) != 0)
            return "";
        return ws.substr($urandom_range(0, 5), 0);
    endfunction

    function automatic string rand_op();
        string ops;
        ops = "+-*/";
        return ops.substr($urandom_range(0, 3), 0);
    endfunction

    task automatic test_random_exprs();
        string s;
        int terms;
        int pos;
        int sent_before;
        sent_before = char_count + expr_count;
        while (char_count + expr_count - sent_before < RAND_ITEMS)
        begin
            terms = $urandom_range(1, 6);
            s = rand_space();
            for (int i = 0; i < terms; i++)
            begin
                if (i > 0)
                    s = {s, rand_space(), rand_op(), rand_space()};
                s = {s, rand_number()};
            end
            s = {s, rand_space()};
            // some expressions get a corrupt byte
            if ($urandom_range(0, 9) == 0)
            begin
                pos = $urandom_range(0, s.len());
                s = {s.substr(0, pos - 1), string'(8'($urandom_range(0, 255))),
                     s.substr(pos, s.len() - 1)};
            end
            send_expr(s);
            // hold off now and then until every result is back
            if ($urandom_range(0, 39) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        char_code      = 8'd0;
        end_mark       = 1'b0;
        mismatch_count = 0;
        char_count     = 0;
        expr_count     = 0;
        result_count   = 0;
        cycle_count    = 0;
        eval_clear();
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_valid_exprs();
        test_error_cases();
        wait_drained();
        test_random_exprs();
        in_valid <= 1'b0;
        wait_drained();

        $display("covered %0d expressions over %0d characters, %0d results checked",
                 expr_count, char_count, result_count);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
